// ===== rtl/mm64_pkg.sv =====
// ----------------------------------------------------------------------------
// mm64_pkg
// shared constants and the sequencer state type for the murmur64a hasher
// ----------------------------------------------------------------------------
package mm64_pkg;

    // mixing multiplier and xor-shift distance
    localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
    localparam int unsigned MIX_SHIFT = 47;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DISP,
        ST_KMUL1,
        ST_KMUL2,
        ST_AMUL,
        ST_FMUL,
        ST_OUT
    } t_state;

endpackage

// ===== rtl/mm64_mul.sv =====
// ----------------------------------------------------------------------------
// mm64_mul
// iterative 64-bit multiply by the mixing constant, low 64 bits of the product,
// built from one 32x32 multiplier reused for each partial product
// ----------------------------------------------------------------------------
module mm64_mul
    import mm64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    output logic        o_done,
    output logic [63:0] o_prod
);

    localparam logic [31:0] MUL_LO = MIX_MUL[31:0];
    localparam logic [31:0] MUL_HI = MIX_MUL[63:32];

    logic [63:0] r_a;
    logic [63:0] r_prod;
    logic [1:0]  r_step;
    logic        r_busy;
    logic        r_done;

    logic [31:0] mul_x;
    logic [31:0] mul_y;
    logic [63:0] mul_p;

    // step 0: a_lo*m_lo, step 1: a_hi*m_lo, step 2: a_lo*m_hi
    assign mul_x = (r_step == 2'd1) ? r_a[63:32] : r_a[31:0];
    assign mul_y = (r_step == 2'd2) ? MUL_HI : MUL_LO;
    assign mul_p = 64'(mul_x) * 64'(mul_y);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_done <= r_busy && (r_step == 2'd2);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= 2'd0;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == 2'd2) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a <= i_a;
        end
        if (r_busy) begin
            if (r_step == 2'd0) begin
                r_prod <= mul_p;
            end else begin
                r_prod[63:32] <= r_prod[63:32] + mul_p[31:0];
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_prod;

endmodule

// ===== rtl/murmur64a_byte_hash.sv =====
// cost: every multiply by the mixing constant runs on the shared 32x32
// multiplier; a full word needs three multiplies, a 1..7 byte tail one and
// an empty last beat none; a first beat adds one more (length seeding), and
// a last beat adds one for finalization, then the hash is registered for output
// throughput: one input beat at a time, limited by the three dependent multiplies
// reset: synchronous active low, clears seed, accumulator and open-message flag
// ----------------------------------------------------------------------------
// murmur64a_byte_hash
// 64-bit murmurhash64a over a message sent as little-endian 64-bit words
// ----------------------------------------------------------------------------
module murmur64a_byte_hash
    import mm64_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // seed register
    input  logic        i_cfg_wr_en,
    input  logic [63:0] i_cfg_wr_data,
    // input beats
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [63:0] i_word_data,
    input  logic [3:0]  i_byte_count,
    input  logic        i_first_word,
    input  logic        i_last_word,
    input  logic [31:0] i_message_length,
    // result beats
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_hash_value
);

    t_state      r_state, n_state;
    logic [63:0] r_seed;
    logic [63:0] r_acc, n_acc;
    logic        r_in_msg, n_in_msg;
    logic        r_out_valid, n_out_valid;
    logic [63:0] r_hash, n_hash;

    // latched copy of the beat being worked on
    logic [63:0] r_data;
    logic        r_full;
    logic [2:0]  r_cnt;
    logic        r_last;

    logic        in_acc;
    logic        out_free;
    logic        mul_start;
    logic [63:0] mul_a;
    logic        mul_done;
    logic [63:0] mul_prod;
    logic [63:0] tail_mask;

    // only idle takes a beat; the output register lets us take one while a
    // finished hash still waits downstream
    assign o_in_stall = (r_state != ST_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_out_valid || !i_out_stall;

    // keep bytes below the tail count
    always_comb begin
        for (int b = 0; b < 8; b++) begin
            tail_mask[8*b +: 8] = (3'(b) < r_cnt) ? 8'hff : 8'h00;
        end
    end

    mm64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_seed      <= '0;
            r_acc       <= '0;
            r_in_msg    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_acc       <= n_acc;
            r_in_msg    <= n_in_msg;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_seed <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_hash <= n_hash;
        if (in_acc) begin
            r_data <= i_word_data;
            r_cnt  <= i_byte_count[2:0];
            r_last <= i_last_word;
            // any count other than a short last tail is a full word
            r_full <= !i_last_word || (i_byte_count >= 4'd8);
        end
    end

    always_comb begin
        n_state     = r_state;
        n_acc       = r_acc;
        n_in_msg    = r_in_msg;
        n_hash      = r_hash;
        n_out_valid = r_out_valid && i_out_stall;
        mul_start   = 1'b0;
        mul_a       = r_acc;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_first_word) begin
                        // seed ^ (length * m): start the length multiply now
                        mul_start = 1'b1;
                        mul_a     = {32'd0, i_message_length};
                        n_in_msg  = 1'b1;
                        n_state   = ST_INIT;
                    end else if (r_in_msg) begin
                        n_state = ST_DISP;
                    end
                    // beat outside a message is dropped
                end
            end
            ST_INIT: begin
                if (mul_done) begin
                    n_acc   = r_seed ^ mul_prod;
                    n_state = ST_DISP;
                end
            end
            ST_DISP: begin
                mul_start = 1'b1;
                if (r_full) begin
                    mul_a   = r_data;
                    n_state = ST_KMUL1;
                end else if (r_cnt != 3'd0) begin
                    mul_a   = r_acc ^ (r_data & tail_mask);
                    n_state = ST_AMUL;
                end else begin
                    // empty last beat goes straight to finalization
                    mul_a   = r_acc ^ (r_acc >> MIX_SHIFT);
                    n_state = ST_FMUL;
                end
            end
            ST_KMUL1: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = mul_prod ^ (mul_prod >> MIX_SHIFT);
                    n_state   = ST_KMUL2;
                end
            end
            ST_KMUL2: begin
                if (mul_done) begin
                    mul_start = 1'b1;
                    mul_a     = r_acc ^ mul_prod;
                    n_state   = ST_AMUL;
                end
            end
            ST_AMUL: begin
                if (mul_done) begin
                    n_acc = mul_prod;
                    if (r_last) begin
                        mul_start = 1'b1;
                        mul_a     = mul_prod ^ (mul_prod >> MIX_SHIFT);
                        n_state   = ST_FMUL;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_FMUL, ST_OUT: begin
                // product holds in the multiplier until the next start
                if ((mul_done || (r_state == ST_OUT)) && out_free) begin
                    n_hash      = mul_prod ^ (mul_prod >> MIX_SHIFT);
                    n_out_valid = 1'b1;
                    n_in_msg    = 1'b0;
                    n_state     = ST_IDLE;
                end else if (mul_done) begin
                    n_state = ST_OUT;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_hash_value = r_hash;

`ifndef NO_ASSERTIONS
    // a multiply completes only while the sequencer waits for one
    a_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == ST_INIT || r_state == ST_KMUL1 ||
                      r_state == ST_KMUL2 || r_state == ST_AMUL || r_state == ST_FMUL))
        else $error("multiply finished outside a wait state");

    // a new result beat only comes out of finalization
    a_out_from_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FMUL || $past(r_state) == ST_OUT))
        else $error("result beat without finalization");

    // a waiting result is never overwritten by a stalled finalization
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT && r_out_valid && i_out_stall) |=> (r_state == ST_OUT))
        else $error("finalization left while the output was blocked");
`endif

endmodule
